[design/atdffa_pkg.sv]
// Shared constants and types of the top-down first-fit arena allocator.
package atdffa_pkg;

	localparam int ARENA_BYTES_DEF  = 4096;
	localparam int NUM_ARENAS_DEF   = 4;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int DESC_BYTES_DEF   = 8;
	localparam int MAX_ENTRIES_DEF  = 256;

	localparam int OP_W   = 2;
	localparam int SIZE_W = 13;
	localparam int ADDR_W = 14;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

endpackage

[design/atdffa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module atdffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/arena_top_down_first_fit_allocator.sv]
// Top level of the top-down first-fit arena allocator with descriptor tables.
//
// The block manages NUM_ARENAS arenas of ARENA_BYTES each. Every arena starts with a
// header of HEADER_BYTES, followed by a descriptor table of DESC_BYTES per entry that
// grows upward and is kept sorted by descending data offset; data is placed from the top
// of the arena down. An allocate item tries the opened arenas from the newest to the
// oldest, takes the first gap from the top that holds the request while leaving room for
// one more descriptor, and places the data at the upper end of that gap. When nothing
// fits, a new arena is opened and tried. A free item removes the descriptor whose offset
// matches and closes up the table; a release item empties everything at once. Each item
// yields exactly one result item with a success flag and the granted address (zero when
// the item did not allocate). The descriptors live in one synchronous RAM of
// NUM_ARENAS*MAX_ENTRIES words, and the whole cost of an item is set by its single read
// port: the search reads one descriptor per cycle, and inserting or removing an entry
// moves one descriptor per cycle. The time an allocate takes thus grows with the arenas
// tried and the descriptors examined and moved, and that of a free with the descriptors
// examined and moved; release and unused operations involve no table access. With the
// default sizes a full table holds 256 entries. One item is worked on at a time; the
// next item is accepted as soon as the previous one has reached the output register,
// even while that result is still stalled downstream. No clearing pass is needed after
// reset, as table entries above the live count are never read.
module arena_top_down_first_fit_allocator #(
	parameter int ARENA_BYTES  = atdffa_pkg::ARENA_BYTES_DEF,
	parameter int NUM_ARENAS   = atdffa_pkg::NUM_ARENAS_DEF,
	parameter int HEADER_BYTES = atdffa_pkg::HEADER_BYTES_DEF,
	parameter int DESC_BYTES   = atdffa_pkg::DESC_BYTES_DEF,
	parameter int MAX_ENTRIES  = atdffa_pkg::MAX_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [atdffa_pkg::OP_W-1:0]     operation,
	input  logic [atdffa_pkg::SIZE_W-1:0]   request_size,
	input  logic [atdffa_pkg::ADDR_W-1:0]   free_address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            success,
	output logic [atdffa_pkg::ADDR_W-1:0]   granted_address
);

	localparam int SIZE_W    = atdffa_pkg::SIZE_W;
	localparam int ADDR_W    = atdffa_pkg::ADDR_W;
	localparam int OFF_W     = $clog2(ARENA_BYTES);
	localparam int IDX_W     = $clog2(MAX_ENTRIES + 1);
	localparam int ARN_W     = $clog2(NUM_ARENAS + 1);
	localparam int CIX_W     = (NUM_ARENAS > 1) ? $clog2(NUM_ARENAS) : 1;
	localparam int DEPTH     = NUM_ARENAS * MAX_ENTRIES;
	localparam int RAM_AW    = $clog2(DEPTH);
	localparam int ENT_W     = OFF_W + SIZE_W;
	localparam int NEED_MAX  = HEADER_BYTES + (MAX_ENTRIES + 1) * DESC_BYTES;
	localparam int CMP_W     = $clog2(NEED_MAX + ARENA_BYTES + 2 * (2 ** SIZE_W)) + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_NEXT,
		S_A_ARENA,
		S_A_CHK,
		S_A_SCAN,
		S_A_TAIL,
		S_A_INS,
		S_A_SHIFT,
		S_F_START,
		S_F_SCAN,
		S_F_INS,
		S_F_SHIFT,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [SIZE_W-1:0]   size_q;
	logic [ARN_W-1:0]    ar_q;
	logic [ARN_W-1:0]    open_q;
	logic [IDX_W-1:0]    cnt_q [NUM_ARENAS];
	logic [IDX_W-1:0]    i_q;
	logic [IDX_W-1:0]    j_q;
	logic [IDX_W-1:0]    slot_q;
	logic [CMP_W-1:0]    upper_q;
	logic [OFF_W-1:0]    newoff_q;
	logic [OFF_W-1:0]    foff_q;
	logic                tried_new_q;
	logic                res_ok_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic                out_valid_q;
	logic                success_q;
	logic [ADDR_W-1:0]   granted_q;

	logic                ram_wr_en;
	logic [RAM_AW-1:0]   ram_wr_addr;
	logic [ENT_W-1:0]    ram_wr_data;
	logic                ram_rd_en;
	logic [RAM_AW-1:0]   ram_rd_addr;
	logic [ENT_W-1:0]    ram_rd_data;

	logic [IDX_W-1:0]    cur_c;
	logic [OFF_W-1:0]    rd_off;
	logic [SIZE_W-1:0]   rd_sz;
	logic [CMP_W-1:0]    need;
	logic [CMP_W-1:0]    lower_plus;
	logic                fit_gap;
	logic                fit_tail;
	logic [ARN_W-1:0]    fa;
	logic [OFF_W-1:0]    fa_off;
	logic [31:0]         fa_base;
	logic [31:0]         grant_full;
	logic                in_acc;

	// Table word of entry k in arena a.
	function automatic logic [RAM_AW-1:0] ent_addr(input logic [ARN_W-1:0] a,
			input logic [IDX_W-1:0] k);
		logic [31:0] t;
		t = 32'(a) * 32'(MAX_ENTRIES) + 32'(k);
		return t[RAM_AW-1:0];
	endfunction

	atdffa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign cur_c      = cnt_q[ar_q[CIX_W-1:0]];
	assign rd_off     = ram_rd_data[ENT_W-1:SIZE_W];
	assign rd_sz      = ram_rd_data[SIZE_W-1:0];
	// End of the descriptor table once it has grown by one entry.
	assign need       = CMP_W'(HEADER_BYTES) + (CMP_W'(cur_c) + CMP_W'(1)) * CMP_W'(DESC_BYTES);
	assign lower_plus = CMP_W'(rd_off) + CMP_W'(rd_sz) + CMP_W'(size_q);
	assign fit_gap    = (upper_q >= lower_plus);
	assign fit_tail   = (upper_q >= need + CMP_W'(size_q));
	assign grant_full = 32'(ar_q) * 32'(ARENA_BYTES) + 32'(newoff_q);

	// Split a free address into arena index and offset by comparing against arena bases.
	always_comb begin
		fa = '0;
		for (int k = 1; k <= NUM_ARENAS; k++) begin
			if (32'(free_address) >= 32'(k) * 32'(ARENA_BYTES)) begin
				fa = ARN_W'(k);
			end
		end
		fa_base = 32'(fa) * 32'(ARENA_BYTES);
		fa_off  = OFF_W'(32'(free_address) - fa_base);
	end

	// Table port control.
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = ent_addr(ar_q, i_q);
		ram_wr_en   = 1'b0;
		ram_wr_addr = ent_addr(ar_q, j_q);
		ram_wr_data = ram_rd_data;
		case (state_q)
			S_A_ARENA: begin
				ram_rd_en   = (cur_c != '0) && (cur_c < IDX_W'(MAX_ENTRIES));
				ram_rd_addr = ent_addr(ar_q, cur_c - IDX_W'(1));
			end
			S_A_CHK: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = ent_addr(ar_q, '0);
			end
			S_A_SCAN, S_F_SCAN: begin
				ram_rd_en   = ((IDX_W+1)'(i_q) + (IDX_W+1)'(1)) < (IDX_W+1)'(cur_c);
				ram_rd_addr = ent_addr(ar_q, i_q + IDX_W'(1));
			end
			S_A_INS: begin
				if (j_q > slot_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = ent_addr(ar_q, j_q - IDX_W'(1));
				end else begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = ent_addr(ar_q, slot_q);
					ram_wr_data = {newoff_q, size_q};
				end
			end
			S_A_SHIFT: begin
				ram_wr_en   = 1'b1;
				ram_rd_en   = (j_q - IDX_W'(1)) > slot_q;
				ram_rd_addr = ent_addr(ar_q, j_q - IDX_W'(2));
			end
			S_F_START: begin
				ram_rd_en   = (cur_c != '0);
				ram_rd_addr = ent_addr(ar_q, '0);
			end
			S_F_INS: begin
				ram_rd_en   = ((IDX_W+1)'(j_q) + (IDX_W+1)'(1)) < (IDX_W+1)'(cur_c);
				ram_rd_addr = ent_addr(ar_q, j_q + IDX_W'(1));
			end
			S_F_SHIFT: begin
				ram_wr_en   = 1'b1;
				ram_rd_en   = ((IDX_W+1)'(j_q) + (IDX_W+1)'(2)) < (IDX_W+1)'(cur_c);
				ram_rd_addr = ent_addr(ar_q, j_q + IDX_W'(2));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			open_q      <= '0;
			tried_new_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_ARENAS; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			// A result leaving while the next one is loaded is handled in S_DONE.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						size_q      <= request_size;
						res_ok_q    <= 1'b0;
						res_addr_q  <= '0;
						tried_new_q <= 1'b0;
						case (atdffa_pkg::op_t'(operation))
							atdffa_pkg::OP_ALLOC: begin
								if (request_size == '0) begin
									state_q <= S_DONE;
								end else if (open_q == '0) begin
									ar_q    <= '0;
									state_q <= S_A_NEXT;
								end else begin
									ar_q    <= open_q - ARN_W'(1);
									state_q <= S_A_ARENA;
								end
							end
							atdffa_pkg::OP_FREE: begin
								ar_q   <= fa;
								foff_q <= fa_off;
								if (fa >= open_q) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_F_START;
								end
							end
							atdffa_pkg::OP_RELEASE: begin
								open_q <= '0;
								for (int k = 0; k < NUM_ARENAS; k++) begin
									cnt_q[k] <= '0;
								end
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				// The arena just tried has no room: move to the next older one, or open a fresh arena
				// once the oldest has been tried and one is left; a failed fresh arena ends the item.
				S_A_NEXT: begin
					if (tried_new_q) begin
						state_q <= S_DONE;
					end else if (ar_q != '0) begin
						ar_q    <= ar_q - ARN_W'(1);
						state_q <= S_A_ARENA;
					end else if (open_q < ARN_W'(NUM_ARENAS)) begin
						ar_q                     <= open_q;
						cnt_q[open_q[CIX_W-1:0]] <= '0;
						open_q                   <= open_q + ARN_W'(1);
						tried_new_q              <= 1'b1;
						state_q                  <= S_A_ARENA;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_A_ARENA: begin
					upper_q <= CMP_W'(ARENA_BYTES);
					i_q     <= '0;
					if (cur_c >= IDX_W'(MAX_ENTRIES)) begin
						state_q <= S_A_NEXT;
					end else if (cur_c == '0) begin
						state_q <= S_A_TAIL;
					end else begin
						state_q <= S_A_CHK;
					end
				end
				// The lowest data must leave room for the grown table.
				S_A_CHK: begin
					if (CMP_W'(rd_off) < need) begin
						state_q <= S_A_NEXT;
					end else begin
						state_q <= S_A_SCAN;
					end
				end
				S_A_SCAN: begin
					if (fit_gap) begin
						slot_q   <= i_q;
						newoff_q <= OFF_W'(upper_q - CMP_W'(size_q));
						j_q      <= cur_c;
						state_q  <= S_A_INS;
					end else begin
						upper_q <= CMP_W'(rd_off);
						if (((IDX_W+1)'(i_q) + (IDX_W+1)'(1)) < (IDX_W+1)'(cur_c)) begin
							i_q <= i_q + IDX_W'(1);
						end else begin
							state_q <= S_A_TAIL;
						end
					end
				end
				S_A_TAIL: begin
					if (fit_tail) begin
						slot_q   <= cur_c;
						newoff_q <= OFF_W'(upper_q - CMP_W'(size_q));
						j_q      <= cur_c;
						state_q  <= S_A_INS;
					end else begin
						state_q <= S_A_NEXT;
					end
				end
				S_A_INS: begin
					if (j_q > slot_q) begin
						state_q <= S_A_SHIFT;
					end else begin
						cnt_q[ar_q[CIX_W-1:0]] <= cur_c + IDX_W'(1);
						res_ok_q               <= 1'b1;
						res_addr_q             <= grant_full[ADDR_W-1:0];
						state_q                <= S_DONE;
					end
				end
				S_A_SHIFT: begin
					j_q <= j_q - IDX_W'(1);
					if ((j_q - IDX_W'(1)) <= slot_q) begin
						state_q <= S_A_INS;
					end
				end
				S_F_START: begin
					i_q <= '0;
					if (cur_c == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_SCAN;
					end
				end
				S_F_SCAN: begin
					if (rd_off == foff_q) begin
						j_q     <= i_q;
						state_q <= S_F_INS;
					end else if (((IDX_W+1)'(i_q) + (IDX_W+1)'(1)) < (IDX_W+1)'(cur_c)) begin
						i_q <= i_q + IDX_W'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_F_INS: begin
					if (((IDX_W+1)'(j_q) + (IDX_W+1)'(1)) < (IDX_W+1)'(cur_c)) begin
						state_q <= S_F_SHIFT;
					end else begin
						cnt_q[ar_q[CIX_W-1:0]] <= cur_c - IDX_W'(1);
						res_ok_q               <= 1'b1;
						state_q                <= S_DONE;
					end
				end
				S_F_SHIFT: begin
					j_q <= j_q + IDX_W'(1);
					if (((IDX_W+1)'(j_q) + (IDX_W+1)'(2)) >= (IDX_W+1)'(cur_c)) begin
						cnt_q[ar_q[CIX_W-1:0]] <= cur_c - IDX_W'(1);
						res_ok_q               <= 1'b1;
						state_q                <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						success_q   <= res_ok_q;
						granted_q   <= res_addr_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign success         = success_q;
	assign granted_address = granted_q;

	a_open_range: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= ARN_W'(NUM_ARENAS))
		else $error("more arenas open than exist");

	a_shift_above_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_SHIFT |-> j_q > slot_q)
		else $error("insert shift ran below the target slot");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_INS && j_q == slot_q) |-> cur_c < IDX_W'(MAX_ENTRIES))
		else $error("insert into a full descriptor table");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !success) |-> granted_address == '0)
		else $error("failed item carries a nonzero address");

	a_free_live_arena: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_F_SCAN || state_q == S_F_SHIFT) |-> ar_q < open_q)
		else $error("free works on an arena that is not open");

endmodule

[dv/arena_alloc_checker.sv]
// Checker for the arena allocator: predicts each result item and compares it.
`timescale 1ns / 100ps
module arena_alloc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [atdffa_pkg::OP_W-1:0]   operation,
	input  logic [atdffa_pkg::SIZE_W-1:0] request_size,
	input  logic [atdffa_pkg::ADDR_W-1:0] free_address,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          success,
	input  logic [atdffa_pkg::ADDR_W-1:0] granted_address,
	output int                            fail_count,
	output int                            pending
);

	localparam int AB = atdffa_pkg::ARENA_BYTES_DEF;
	localparam int NA = atdffa_pkg::NUM_ARENAS_DEF;
	localparam int HB = atdffa_pkg::HEADER_BYTES_DEF;
	localparam int DB = atdffa_pkg::DESC_BYTES_DEF;
	localparam int ME = atdffa_pkg::MAX_ENTRIES_DEF;
	localparam int ADDR_W = atdffa_pkg::ADDR_W;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] addr;
	} grant_t;

	int unsigned desc_off[NA*ME];
	int unsigned desc_len[NA*ME];
	int unsigned live[NA];
	int unsigned opened;
	grant_t      grant_q[$];

	initial begin
		fail_count = 0;
		pending = 0;
		opened = 0;
		foreach (live[i]) live[i] = 0;
	end

	function automatic bit fit_arena(int unsigned a, int unsigned sz, output int unsigned got);
		int unsigned base, c, need, upper, lower, slot;
		bit found;
		base = a * ME;
		c = live[a];
		found = 0;
		slot = 0;
		got = 0;
		if (c >= ME) return 0;
		need = HB + (c + 1) * DB;
		if (c > 0 && desc_off[base+c-1] < need) return 0;
		upper = AB;
		for (int i = 0; i < c; i++) begin
			lower = desc_off[base+i] + desc_len[base+i];
			if (upper >= lower && upper - lower >= sz) begin
				slot = i;
				found = 1;
				break;
			end
			upper = desc_off[base+i];
		end
		if (!found) begin
			if (upper < need || upper - need < sz) return 0;
			slot = c;
		end
		for (int j = c; j > slot; j--) begin
			desc_off[base+j] = desc_off[base+j-1];
			desc_len[base+j] = desc_len[base+j-1];
		end
		desc_off[base+slot] = upper - sz;
		desc_len[base+slot] = sz;
		live[a] = c + 1;
		got = upper - sz;
		return 1;
	endfunction

	function automatic grant_t predict_grant(atdffa_pkg::op_t op, int unsigned sz,
			int unsigned fa);
		grant_t g;
		int unsigned off, a, base, c;
		g = '0;
		case (op)
			atdffa_pkg::OP_ALLOC: begin
				if (sz != 0) begin
					for (int k = opened; k > 0; k--) begin
						if (!g.ok && fit_arena(k - 1, sz, off)) begin
							g.ok = 1;
							g.addr = ADDR_W'((k - 1) * AB + off);
						end
					end
					if (!g.ok && opened < NA) begin
						a = opened;
						live[a] = 0;
						opened = a + 1;
						if (fit_arena(a, sz, off)) begin
							g.ok = 1;
							g.addr = ADDR_W'(a * AB + off);
						end
					end
				end
			end
			atdffa_pkg::OP_FREE: begin
				a = fa / AB;
				off = fa % AB;
				if (a < opened && a < NA) begin
					base = a * ME;
					c = live[a];
					for (int i = 0; i < c; i++) begin
						if (!g.ok && desc_off[base+i] == off) begin
							for (int j = i; j + 1 < c; j++) begin
								desc_off[base+j] = desc_off[base+j+1];
								desc_len[base+j] = desc_len[base+j+1];
							end
							live[a] = c - 1;
							g.ok = 1;
						end
					end
				end
			end
			atdffa_pkg::OP_RELEASE: begin
				foreach (live[i]) live[i] = 0;
				opened = 0;
			end
			default: ;
		endcase
		return g;
	endfunction

	task automatic report(string what, int unsigned got, int unsigned want);
		$display("error at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		grant_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (grant_q.size() == 0) begin
					report("unexpected result item, success", 32'(success), 0);
				end else begin
					want = grant_q.pop_front();
					if (success !== want.ok)
						report("success", 32'(success), 32'(want.ok));
					if (granted_address !== want.addr)
						report("granted_address", 32'(granted_address), 32'(want.addr));
				end
			end
			if (in_valid && !in_stall)
				grant_q.push_back(predict_grant(atdffa_pkg::op_t'(operation),
					32'(request_size), 32'(free_address)));
			pending = grant_q.size();
		end
	end
endmodule

[dv/testbench.sv]
// Top of the arena allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

	localparam int OP_W   = atdffa_pkg::OP_W;
	localparam int SIZE_W = atdffa_pkg::SIZE_W;
	localparam int ADDR_W = atdffa_pkg::ADDR_W;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [OP_W-1:0]   operation;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] free_address;
	logic              out_valid;
	logic              out_stall;
	logic              success;
	logic [ADDR_W-1:0] granted_address;
	int                fail_count;
	int                pending;

	// Percentages of idle sender cycles and stalled receiver cycles for the current phase.
	int                idle_pct;
	int                stall_pct;
	// Set by the stimulus to ask the receiver for one long hold-off.
	bit                hold_req;
	int                quiet_cycles;
	// Addresses granted so far and not yet freed, used to build well-formed frees.
	logic [ADDR_W-1:0] granted_q[$];

	arena_top_down_first_fit_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .request_size(request_size), .free_address(free_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.success(success), .granted_address(granted_address)
	);

	arena_alloc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .request_size(request_size), .free_address(free_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.success(success), .granted_address(granted_address),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		operation = atdffa_pkg::OP_NONE;
		request_size = '0;
		free_address = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The receiver stalls at random, and once holds off for a long stretch so that
	// the block's output register fills and its input stall goes up.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 0;
				out_stall <= ($urandom_range(99) < stall_pct);
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Successful allocations are remembered so that later frees can hit live entries.
	// Address zero lies in a header and is never granted, so a nonzero address marks
	// an allocate.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && success && granted_address != '0)
			granted_q.push_back(granted_address);
	end

	// The watchdog ends a run in which no item moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("arena_top_down_first_fit_allocator: mismatch");
			$finish;
		end
	end

	// Offers one item and returns in the time step in which it is accepted, so that
	// the next call makes the only assignment to each input in that step.
	task automatic send(atdffa_pkg::op_t op, int unsigned sz, int unsigned fa);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		request_size <= SIZE_W'(sz);
		free_address <= ADDR_W'(fa);
		if (op == atdffa_pkg::OP_RELEASE) granted_q.delete();
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random();
		int unsigned pick, sz, idx;
		pick = $urandom_range(99);
		if (pick < 52) begin
			// Mostly small requests so that tables grow deep, a few large ones.
			case ($urandom_range(9))
				0:       sz = $urandom_range(1, 4096);
				1:       sz = $urandom_range(512, 2048);
				2, 3:    sz = $urandom_range(1, 4);
				default: sz = $urandom_range(1, 64);
			endcase
			send(atdffa_pkg::OP_ALLOC, sz, $urandom_range(16383));
		end else if (pick < 86 && granted_q.size() > 0) begin
			idx = $urandom_range(granted_q.size() - 1);
			send(atdffa_pkg::OP_FREE, $urandom_range(8191), 32'(granted_q[idx]));
			granted_q.delete(idx);
		end else if (pick < 94) begin
			// A free that mostly misses, with every address bit at random.
			send(atdffa_pkg::OP_FREE, $urandom_range(8191), $urandom_range(16383));
		end else if (pick < 96) begin
			send(atdffa_pkg::OP_RELEASE, $urandom_range(8191), $urandom_range(16383));
		end else if (pick < 98) begin
			send(atdffa_pkg::OP_NONE, $urandom_range(8191), $urandom_range(16383));
		end else begin
			send(atdffa_pkg::OP_ALLOC, 0, $urandom_range(16383));
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// Directed part: the largest and smallest sizes, an empty arena left open by an
		// oversized request, a zero size, frees that miss, the unused operation, every
		// arena in use, and reuse of a gap left by a free.
		send(atdffa_pkg::OP_ALLOC, 1, 0);
		send(atdffa_pkg::OP_ALLOC, 4096, 0);
		send(atdffa_pkg::OP_ALLOC, 0, 0);
		send(atdffa_pkg::OP_ALLOC, 8191, 0);
		send(atdffa_pkg::OP_ALLOC, 4095, 0);
		send(atdffa_pkg::OP_ALLOC, 4072, 0);
		send(atdffa_pkg::OP_FREE, 0, 16383);
		send(atdffa_pkg::OP_FREE, 0, 4095);
		send(atdffa_pkg::OP_FREE, 0, 4095);
		send(atdffa_pkg::OP_FREE, 0, 0);
		send(atdffa_pkg::OP_NONE, 8191, 16383);
		send(atdffa_pkg::OP_RELEASE, 0, 0);
		repeat (5) send(atdffa_pkg::OP_ALLOC, 4000, 0);
		send(atdffa_pkg::OP_RELEASE, 0, 0);
		send(atdffa_pkg::OP_ALLOC, 100, 0);
		send(atdffa_pkg::OP_ALLOC, 100, 0);
		send(atdffa_pkg::OP_ALLOC, 100, 0);
		send(atdffa_pkg::OP_FREE, 0, 3896);
		send(atdffa_pkg::OP_ALLOC, 50, 0);
		send(atdffa_pkg::OP_FREE, 0, 3946);
		send(atdffa_pkg::OP_RELEASE, 0, 0);

		// Random part in idling phases: none, sender idle, receiver stalling, both, and one long receiver hold-off.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				3: begin idle_pct = 13; stall_pct = 13; end
				default: begin idle_pct = 0; stall_pct = 0; hold_req = 1; end
			endcase
			for (int n = 0; n < 280; n++) send_random();
		end
		in_valid <= 1'b0;

		// A wait on the clock lets the checker record the last accepted item first.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("arena_top_down_first_fit_allocator: match");
		else
			$display("arena_top_down_first_fit_allocator: mismatch");
		$finish;
	end
endmodule

[files.f]
design/atdffa_pkg.sv
design/atdffa_ram.sv
design/arena_top_down_first_fit_allocator.sv
dv/arena_alloc_checker.sv
dv/testbench.sv
